>>> sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define EDSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edss assertion failed");

// antecedent holds in this cycle, consequent in the next cycle
`define EDSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edss assertion failed");

`endif

>>> sv/edss_pkg.sv
// types and constants for the date signature scanner
package edss_pkg;

  localparam int WinDepth = 16;
  localparam int YearW = 19;
  localparam int MdW = 13;

  localparam logic [7:0] ColonCode = 8'h3A;
  localparam logic [7:0] SpaceCode = 8'h20;
  localparam logic signed [8:0] DigitBase = 9'sd48;
  localparam logic [15:0] LimitReset = 16'd5000;

  typedef struct packed {
    logic                    found;
    logic signed [YearW-1:0] year;
    logic signed [MdW-1:0]   month;
    logic signed [MdW-1:0]   day;
  } date_t;

  function automatic logic signed [8:0] digit_of(input logic [7:0] b);
    digit_of = $signed({1'b0, b}) - DigitBase;
  endfunction

endpackage

>>> sv/edss_scan.sv
// sliding byte window, signature match and held date
module edss_scan (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     data_byte,
  input  logic           end_of_file,
  input  logic [15:0]    search_limit,
  output edss_pkg::date_t result
);
  import edss_pkg::*;

  logic [7:0]              win [WinDepth];
  logic [7:0]              w   [WinDepth+1];
  logic [15:0]             bytes_seen;
  logic                    match_seen;
  logic signed [YearW-1:0] held_year;
  logic signed [MdW-1:0]   held_month;
  logic signed [MdW-1:0]   held_day;

  logic                    in_range;
  logic                    hit;
  logic signed [8:0]       dg [10];
  logic signed [YearW-1:0] cand_year;
  logic signed [MdW-1:0]   cand_month;
  logic signed [MdW-1:0]   cand_day;

  always_comb begin
    for (int k = 0; k < WinDepth; k++) begin
      w[k] = win[k];
    end
    w[WinDepth] = data_byte;
  end

  always_comb begin
    for (int k = 0; k < 10; k++) begin
      dg[k] = digit_of(w[k]);
    end
  end

  assign in_range = (bytes_seen >= 16'(WinDepth)) && (bytes_seen < search_limit);
  assign hit = in_range && (w[4] == ColonCode) && (w[7] == ColonCode) &&
               (w[10] == SpaceCode) && (w[13] == ColonCode) && (w[16] == ColonCode);

  assign cand_year  = YearW'(dg[0]) * 19'sd1000 + YearW'(dg[1]) * 19'sd100 +
                      YearW'(dg[2]) * 19'sd10 + YearW'(dg[3]);
  assign cand_month = MdW'(dg[5]) * 13'sd10 + MdW'(dg[6]);
  assign cand_day   = MdW'(dg[8]) * 13'sd10 + MdW'(dg[9]);

  always_comb begin
    result.found = hit || match_seen;
    result.year  = hit ? cand_year  : held_year;
    result.month = hit ? cand_month : held_month;
    result.day   = hit ? cand_day   : held_day;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_file)) begin
      for (int k = 0; k < WinDepth; k++) begin
        win[k] <= '0;
      end
      bytes_seen <= '0;
      match_seen <= 1'b0;
      held_year  <= '0;
      held_month <= '0;
      held_day   <= '0;
    end else if (step) begin
      for (int k = 0; k < WinDepth; k++) begin
        win[k] <= w[k+1];
      end
      if (bytes_seen != 16'hFFFF) begin
        bytes_seen <= bytes_seen + 16'd1;
      end
      if (hit) begin
        match_seen <= 1'b1;
        held_year  <= cand_year;
        held_month <= cand_month;
        held_day   <= cand_day;
      end
    end
  end

endmodule

>>> sv/exif_date_signature_scanner_core.sv
// top level of the date signature scanner
//
//  channel   direction  handshake               payload
//  input     in         in_valid / in_ready     data_byte, end_of_file
//  result    out        out_valid / out_ready   found, year, month, day
//  config    in         cfg_we                  cfg_wdata (search_limit)
//
// one byte per cycle unless a held result stalls the input: input register, then window shift and match compare
// a result is loaded into the output register when its end_of_file byte leaves the input register
// a held result only stalls the input when the next end_of_file byte reaches it
// synchronous reset clears the window and sets search_limit to 5000
module exif_date_signature_scanner_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           data_byte,
  input  logic                                 end_of_file,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 found,
  output logic signed [edss_pkg::YearW-1:0]    year,
  output logic signed [edss_pkg::MdW-1:0]      month,
  output logic signed [edss_pkg::MdW-1:0]      day,
  input  logic                                 cfg_we,
  input  logic [15:0]                          cfg_wdata
);
  import edss_pkg::*;

  logic [15:0] search_limit;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        out_free;
  logic        s1_adv;
  date_t       scan_result;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_limit <= LimitReset;
    end else if (cfg_we) begin
      search_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= end_of_file;
    end
  end

  edss_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_adv),
    .data_byte   (s1_byte),
    .end_of_file (s1_last),
    .search_limit(search_limit),
    .result      (scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      found <= scan_result.found;
      year  <= scan_result.year;
      month <= scan_result.month;
      day   <= scan_result.day;
    end
  end

`include "assert_macros.svh"

  `EDSS_ASSERT_IMP(a_nofind_zero, out_valid && !found, year == '0 && month == '0 && day == '0)
  `EDSS_ASSERT_IMP(a_stall_cause, !in_ready, s1_valid && s1_last && out_valid && !out_ready)
  `EDSS_ASSERT_NXT(a_final_loads, s1_adv && s1_last, out_valid)
  `EDSS_ASSERT_NXT(a_final_holds, s1_valid && s1_last && !out_free, s1_valid && s1_last)

endmodule
